// ===== hdl/pdv_pkg.sv =====
// ----------------------------------------------------------------------------
// pdv_pkg: shared types and constants of the percent decode validator
// Character codes, phase and status codes, item structs and helper functions.
// ----------------------------------------------------------------------------
package pdv_pkg;

  localparam int unsigned CfgIdxW = 4;
  localparam int unsigned CfgDataW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxCapacity  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgIdxMultiline = CfgIdxW'(1);

  localparam logic [15:0] CapacityReset = 16'd64;

  // character codes
  localparam logic [7:0] ChPlus    = 8'h2b;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChDel     = 8'h7f;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChCr      = 8'h0d;
  localparam logic [7:0] ChLf      = 8'h0a;
  localparam logic [7:0] ChDigit0  = 8'h30;
  localparam logic [7:0] ChDigit9  = 8'h39;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] ChUpperF  = 8'h46;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChLowerF  = 8'h66;
  localparam logic [7:0] HexTen    = 8'd10;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_HIGH   = 2'd1,
    PH_LOW    = 2'd2,
    PH_SKIP   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_MALF  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_last;
    logic       no_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       done_res;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic [15:0] capacity;
    logic        multiline_mode;
  } cfg_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nibble;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t       h;
    logic [7:0] v;
    h = '0;
    v = '0;
    if (c >= ChDigit0 && c <= ChDigit9) begin
      v = c - ChDigit0;
      h.ok = 1'b1;
    end else if (c >= ChLowerA && c <= ChLowerF) begin
      v = c - ChLowerA + HexTen;
      h.ok = 1'b1;
    end else if (c >= ChUpperA && c <= ChUpperF) begin
      v = c - ChUpperA + HexTen;
      h.ok = 1'b1;
    end
    h.nibble = v[3:0];
    return h;
  endfunction

  function automatic logic byte_allowed(input logic [7:0] b, input logic multiline);
    logic brk;
    brk = multiline && (b == ChTab || b == ChCr || b == ChLf);
    return !(b == ChDel) && !(b < ChSpace && !brk);
  endfunction

endpackage

// ===== hdl/pdv_in_if.sv =====
// ----------------------------------------------------------------------------
// pdv_in_if: source byte channel
// Valid/ready channel carrying one raw source character per beat.
// ----------------------------------------------------------------------------
interface pdv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;
  logic       no_byte;

  modport source (output valid, in_byte, is_last, no_byte, input ready);
  modport sink   (input valid, in_byte, is_last, no_byte, output ready);
endinterface

// ===== hdl/pdv_out_if.sv =====
// ----------------------------------------------------------------------------
// pdv_out_if: result channel
// Valid/ready channel carrying one decode result per beat.
// ----------------------------------------------------------------------------
interface pdv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       done_res;
  logic [1:0] status;

  modport source (output valid, out_byte, out_valid, done_res, status, input ready);
  modport sink   (input valid, out_byte, out_valid, done_res, status, output ready);
endinterface

// ===== hdl/pdv_cfg_if.sv =====
// ----------------------------------------------------------------------------
// pdv_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
interface pdv_cfg_if;
  import pdv_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/pdv_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pdv_cfg_regs: configuration registers
// Holds capacity and multiline mode; always ready for a write beat.
// ----------------------------------------------------------------------------
module pdv_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  pdv_cfg_if.sink       cfg,
  output pdv_pkg::cfg_t cfg_o
);
  import pdv_pkg::*;

  logic [15:0] capacity_q;
  logic        multiline_q;
  logic        wr_en;

  assign cfg.ready = 1'b1;
  assign wr_en     = cfg.valid && cfg.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= CapacityReset;
      multiline_q <= 1'b0;
    end else if (wr_en) begin
      if (cfg.index == CfgIdxCapacity) begin
        capacity_q <= cfg.data[15:0];
      end else if (cfg.index == CfgIdxMultiline) begin
        multiline_q <= cfg.data[0];
      end
    end
  end

  assign cfg_o.capacity       = capacity_q;
  assign cfg_o.multiline_mode = multiline_q;

endmodule

// ===== hdl/pdv_step.sv =====
// ----------------------------------------------------------------------------
// pdv_step: escape state machine and per-byte decode
// Computes the result of one item and updates phase, nibble and count.
// ----------------------------------------------------------------------------
module pdv_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  pdv_pkg::in_item_t item_i,
  input  pdv_pkg::cfg_t     cfg_i,
  output pdv_pkg::result_t  result_o
);
  import pdv_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  nib_q, nib_d;
  logic [15:0] cnt_q, cnt_d;

  hex_t        hv;
  logic        ends;
  logic        fin, fin_last, have_dec;
  status_e     fin_st;
  logic [7:0]  dec;
  logic [16:0] cnt_next;

  assign hv       = hex_value(item_i.in_byte);
  assign ends     = item_i.is_last || item_i.no_byte;
  assign cnt_next = {1'b0, cnt_q} + 17'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NORMAL;
      nib_q   <= '0;
      cnt_q   <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      nib_q   <= nib_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    phase_d  = phase_q;
    nib_d    = nib_q;
    cnt_d    = cnt_q;
    result_o = '0;
    fin      = 1'b0;
    fin_last = 1'b0;
    fin_st   = ST_OK;
    have_dec = 1'b0;
    dec      = '0;

    if (phase_q == PH_SKIP) begin
      if (ends) begin
        phase_d = PH_NORMAL;
        nib_d   = '0;
        cnt_d   = '0;
      end
    end else if (item_i.no_byte) begin
      fin      = 1'b1;
      fin_last = 1'b1;
      if (phase_q == PH_NORMAL) begin
        fin_st = (cfg_i.capacity == '0) ? ST_TRUNC : ST_OK;
      end else begin
        fin_st = ST_MALF;
      end
    end else begin
      case (phase_q)
        PH_NORMAL: begin
          if (cnt_next >= {1'b0, cfg_i.capacity}) begin
            fin      = 1'b1;
            fin_st   = ST_TRUNC;
            fin_last = item_i.is_last;
          end else if (item_i.in_byte == ChPercent) begin
            if (item_i.is_last) begin
              fin      = 1'b1;
              fin_st   = ST_MALF;
              fin_last = 1'b1;
            end else begin
              phase_d = PH_HIGH;
            end
          end else begin
            have_dec = 1'b1;
            dec      = (item_i.in_byte == ChPlus) ? ChSpace : item_i.in_byte;
          end
        end
        PH_HIGH: begin
          if (!hv.ok || item_i.is_last) begin
            fin      = 1'b1;
            fin_st   = ST_MALF;
            fin_last = item_i.is_last;
          end else begin
            nib_d   = hv.nibble;
            phase_d = PH_LOW;
          end
        end
        default: begin
          if (!hv.ok) begin
            fin      = 1'b1;
            fin_st   = ST_MALF;
            fin_last = item_i.is_last;
          end else begin
            have_dec = 1'b1;
            dec      = {nib_q, hv.nibble};
            phase_d  = PH_NORMAL;
            nib_d    = '0;
          end
        end
      endcase

      if (have_dec) begin
        if (!byte_allowed(dec, cfg_i.multiline_mode)) begin
          fin      = 1'b1;
          fin_st   = ST_MALF;
          fin_last = item_i.is_last;
        end else begin
          result_o.out_byte  = dec;
          result_o.out_valid = 1'b1;
          cnt_d              = cnt_next[15:0];
          if (item_i.is_last) begin
            fin      = 1'b1;
            fin_st   = ST_OK;
            fin_last = 1'b1;
          end
        end
      end
    end

    // finishing either restarts the string or skips to its end
    if (fin) begin
      result_o.done_res = 1'b1;
      result_o.status   = fin_st;
      if (fin_st == ST_OK || fin_last) begin
        phase_d = PH_NORMAL;
        nib_d   = '0;
        cnt_d   = '0;
      end else begin
        phase_d = PH_SKIP;
      end
    end
  end

endmodule

// ===== hdl/percent_decode_validator_unit.sv =====
// ----------------------------------------------------------------------------
// percent_decode_validator_unit: streaming form-field decoder with validation
// Decodes '+' and percent escapes, checks decoded bytes and the output limit.
// ----------------------------------------------------------------------------
// Each accepted source beat yields exactly one result beat, via the input
// register and the result register. A new source beat is taken every cycle
// unless the output side stalls: the per-byte decode is a single pass of
// compares and a 16-bit count add that sits between the input register and
// the result register, and the escape state updates as each beat moves into
// the result register. Configuration writes are taken at any time (ready is
// tied high) and should be issued only while no string is in flight.
module percent_decode_validator_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  pdv_in_if.sink    in_i,
  pdv_out_if.source out_o,
  pdv_cfg_if.sink   cfg_i
);
  import pdv_pkg::*;

  cfg_t     cfg;
  in_item_t in_item;

  // input register stage
  logic     s1_valid_q;
  in_item_t s1_item_q;

  // result register stage
  logic     res_valid_q;
  result_t  res_q;
  result_t  step_res;

  logic     advance;
  logic     in_beat;

  pdv_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_i),
    .cfg_o  (cfg)
  );

  // the stage-1 beat moves on when the result register is free or draining
  assign advance    = s1_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_beat    = in_i.valid && in_i.ready;

  assign in_item.in_byte = in_i.in_byte;
  assign in_item.is_last = in_i.is_last;
  assign in_item.no_byte = in_i.no_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_item_q <= in_item;
    end
  end

  pdv_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (s1_item_q),
    .cfg_i     (cfg),
    .result_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign out_o.valid     = res_valid_q;
  assign out_o.out_byte  = res_q.out_byte;
  assign out_o.out_valid = res_q.out_valid;
  assign out_o.done_res  = res_q.done_res;
  assign out_o.status    = res_q.status;

endmodule
